/* sv/onewire_bus_master_defines.svh */
// Assertion macros shared by the onewire bus master RTL.
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising aclk out of reset.
`define OWBM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising aclk out of reset.
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/owbm_pkg.sv */
// Types, codes and timing constants of the onewire bus master.
package owbm_pkg;

    // Width of the microsecond tick counter
    localparam int TIMING_BITS = 10;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 3;
    // Compare width: holds counter + 1 and the sum of two timing registers
    localparam int CMP_W = (TIMING_BITS + 1 > CFG_W + 1) ? TIMING_BITS + 1 : CFG_W + 1;
    localparam logic [TIMING_BITS-1:0] TICK_MAX = '1;

    // Command opcodes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WBIT  = 3'd2;
    localparam logic [2:0] OP_RBIT  = 3'd3;
    localparam logic [2:0] OP_WBYTE = 3'd4;
    localparam logic [2:0] OP_RBYTE = 3'd5;

    // Timing register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LENGTH   = 3'd6;

    // Timing register reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd90;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd390;
    localparam logic [CFG_W-1:0] RST_SHORT_LOW     = 10'd1;
    localparam logic [CFG_W-1:0] RST_LONG_LOW      = 10'd60;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd5;
    localparam logic [CFG_W-1:0] RST_SLOT_LENGTH   = 10'd61;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_SLOT     = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] reset_tail_time;
        logic [CFG_W-1:0] short_low_time;
        logic [CFG_W-1:0] long_low_time;
        logic [CFG_W-1:0] read_sample_wait;
        logic [CFG_W-1:0] slot_length;
    } owbm_timing_t;

    typedef struct packed {
        logic [2:0] cmd_opcode;
        logic [7:0] write_value;
        logic       line_sense;
    } owbm_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_value;
        logic       cmd_rejected;
    } owbm_result_t;

    function automatic logic is_read_op(input logic [2:0] op);
        return (op == OP_RBIT) || (op == OP_RBYTE);
    endfunction

endpackage

/* sv/onewire_bus_master.sv */
// A request's result is offered on m_ once s_ has accepted it: it is held first in the
// input register, then in the result register; a stalled m_ channel can hold it back.
// Throughput: one tick request per cycle while m_ready is high; an input register and a
// result register part the channels, so s_ready stays high while m_ready is high.
// Reset (aresetn low, synchronous): sequencer idle, state cleared, timing
// registers back to 480/90/390/1/60/5/61, both channels empty.
module onewire_bus_master import owbm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_cmd_opcode,
    input  logic [7:0]           s_write_value,
    input  logic                 s_line_sense,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_drive_low,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic                 m_presence,
    output logic [7:0]           m_read_value,
    output logic                 m_cmd_rejected,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic         in_valid_reg;
    owbm_item_t   in_item_reg;
    logic         m_valid_reg;
    owbm_result_t res_reg;
    owbm_result_t res_next;
    owbm_timing_t timing;
    logic         fire;

    // Process the held request when the result register can take it
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    owbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing_o  (timing)
    );

    owbm_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item_i   (in_item_reg),
        .timing_i (timing),
        .res_o    (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd_opcode  <= s_cmd_opcode;
            in_item_reg.write_value <= s_write_value;
            in_item_reg.line_sense  <= s_line_sense;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive_low    = res_reg.drive_low;
    assign m_busy_res     = res_reg.busy_res;
    assign m_done_res     = res_reg.done_res;
    assign m_presence     = res_reg.presence;
    assign m_read_value   = res_reg.read_value;
    assign m_cmd_rejected = res_reg.cmd_rejected;

endmodule

/* sv/owbm_cfg.sv */
// Timing register file of the onewire bus master.
module owbm_cfg import owbm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output owbm_timing_t         timing_o
);

    owbm_timing_t timing_reg;
    owbm_timing_t timing_next;

    assign cfg_ready = 1'b1;
    assign timing_o  = timing_reg;

    // Register write decode; indexes past the list are dropped
    always_comb begin
        timing_next = timing_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_RESET_LOW:     timing_next.reset_low_time     = cfg_data;
                REG_PRESENCE_WAIT: timing_next.presence_wait_time = cfg_data;
                REG_RESET_TAIL:    timing_next.reset_tail_time    = cfg_data;
                REG_SHORT_LOW:     timing_next.short_low_time     = cfg_data;
                REG_LONG_LOW:      timing_next.long_low_time      = cfg_data;
                REG_READ_SAMPLE:   timing_next.read_sample_wait   = cfg_data;
                REG_SLOT_LENGTH:   timing_next.slot_length        = cfg_data;
                default:           timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.reset_low_time     <= RST_RESET_LOW;
            timing_reg.presence_wait_time <= RST_PRESENCE_WAIT;
            timing_reg.reset_tail_time    <= RST_RESET_TAIL;
            timing_reg.short_low_time     <= RST_SHORT_LOW;
            timing_reg.long_low_time      <= RST_LONG_LOW;
            timing_reg.read_sample_wait   <= RST_READ_SAMPLE;
            timing_reg.slot_length        <= RST_SLOT_LENGTH;
        end else begin
            timing_reg <= timing_next;
        end
    end

endmodule

/* sv/owbm_core.sv */
// Bus sequencer: advances the 1-Wire state by one tick per request.
`include "onewire_bus_master_defines.svh"

module owbm_core import owbm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         fire,
    input  owbm_item_t   item_i,
    input  owbm_timing_t timing_i,
    output owbm_result_t res_o
);

    phase_t                 phase_reg, phase_next;
    logic [TIMING_BITS-1:0] tick_count_reg, tick_count_next;
    logic [2:0]             bit_index_reg, bit_index_next;
    logic [7:0]             shift_data_reg, shift_data_next;
    logic [2:0]             op_kind_reg, op_kind_next;
    logic                   presence_reg, presence_next;

    logic                   valid_op;
    logic [CMP_W-1:0]       tick_ext;
    logic [CMP_W-1:0]       tick_plus1;
    logic [TIMING_BITS-1:0] tick_sat;
    logic [CMP_W-1:0]       sample_at;
    logic [CFG_W-1:0]       low_time;
    logic                   is_byte;

    assign valid_op = (item_i.cmd_opcode >= OP_RESET) && (item_i.cmd_opcode <= OP_RBYTE);

    // Next state and tick result
    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_data_next = shift_data_reg;
        op_kind_next    = op_kind_reg;
        presence_next   = presence_reg;
        res_o           = '0;

        // Command start, or rejection while busy
        if (phase_reg == PH_IDLE) begin
            if (valid_op) begin
                op_kind_next    = item_i.cmd_opcode;
                tick_count_next = '0;
                bit_index_next  = '0;
                if (item_i.cmd_opcode == OP_RESET) begin
                    presence_next = 1'b0;
                    phase_next    = PH_RST_LOW;
                end else begin
                    case (item_i.cmd_opcode)
                        OP_WBIT:  shift_data_next = {7'd0, item_i.write_value[0]};
                        OP_WBYTE: shift_data_next = item_i.write_value;
                        default:  shift_data_next = '0;
                    endcase
                    phase_next = PH_SLOT;
                end
            end
        end else if (valid_op) begin
            res_o.cmd_rejected = 1'b1;
        end

        tick_ext   = CMP_W'(tick_count_next);
        tick_plus1 = tick_ext + CMP_W'(1);
        tick_sat   = (tick_count_next == TICK_MAX) ? TICK_MAX
                                                   : tick_count_next + TIMING_BITS'(1);
        sample_at  = CMP_W'(timing_i.short_low_time) + CMP_W'(timing_i.read_sample_wait);
        is_byte    = (op_kind_next == OP_WBYTE) || (op_kind_next == OP_RBYTE);
        if (((op_kind_next == OP_WBIT) || (op_kind_next == OP_WBYTE))
                && !shift_data_next[bit_index_next]) begin
            low_time = timing_i.long_low_time;
        end else begin
            low_time = timing_i.short_low_time;
        end

        res_o.busy_res = (phase_next != PH_IDLE);

        // Work of this tick in the current phase
        unique case (phase_next)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                res_o.drive_low = 1'b1;
                if (tick_plus1 >= CMP_W'(timing_i.reset_low_time)) begin
                    phase_next      = PH_RST_WAIT;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_sat;
                end
            end
            PH_RST_WAIT: begin
                if (tick_ext >= CMP_W'(timing_i.presence_wait_time)) begin
                    presence_next = ~item_i.line_sense;
                    if (timing_i.reset_tail_time == '0) begin
                        res_o.done_res = 1'b1;
                        phase_next     = PH_IDLE;
                    end else begin
                        phase_next      = PH_RST_TAIL;
                        tick_count_next = TIMING_BITS'(1);
                    end
                end else begin
                    tick_count_next = tick_sat;
                end
            end
            PH_RST_TAIL: begin
                if (tick_ext >= CMP_W'(timing_i.reset_tail_time)) begin
                    res_o.done_res = 1'b1;
                    phase_next     = PH_IDLE;
                end else begin
                    tick_count_next = tick_sat;
                end
            end
            PH_SLOT: begin
                res_o.drive_low = (tick_ext < CMP_W'(low_time));
                if (is_read_op(op_kind_next) && (tick_ext == sample_at)) begin
                    shift_data_next[bit_index_next] = item_i.line_sense;
                end
                if (tick_plus1 >= CMP_W'(timing_i.slot_length)) begin
                    if (is_byte && (bit_index_next != 3'd7)) begin
                        bit_index_next  = bit_index_next + 3'd1;
                        tick_count_next = '0;
                    end else begin
                        res_o.done_res = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                end else begin
                    tick_count_next = tick_sat;
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        res_o.presence   = presence_next;
        res_o.read_value = is_read_op(op_kind_next) ? shift_data_next : 8'd0;
    end

    // Sequencer state, advanced once per processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_data_reg <= '0;
            op_kind_reg    <= OP_NONE;
            presence_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_data_reg <= shift_data_next;
            op_kind_reg    <= op_kind_next;
            presence_reg   <= presence_next;
        end
    end

    `OWBM_ASSERT_IMPL(a_done_busy, fire && res_o.done_res, res_o.busy_res, "done without busy")
    `OWBM_ASSERT_IMPL(a_reject_busy, fire && res_o.cmd_rejected, phase_reg != PH_IDLE, "reject while idle")
    `OWBM_ASSERT_NEXT(a_busy_hold, fire && res_o.busy_res && !res_o.done_res, phase_reg != PH_IDLE, "sequencer dropped to idle")
    `OWBM_ASSERT_IMPL(a_bit_index, phase_reg == PH_SLOT && op_kind_reg != OP_WBYTE && op_kind_reg != OP_RBYTE, bit_index_reg == 3'd0, "bit index moved in single slot")

endmodule
